// ===== hdl/psg_pkg.sv =====
// Shared types, constants and tables for the three-voice sound generator.
// No dependencies; imported by every module of the block.
package psg_pkg;

  // Bus operation codes on the input mode field
  localparam logic [2:0] MODE_SEL    = 3'd0;
  localparam logic [2:0] MODE_WR     = 3'd1;
  localparam logic [2:0] MODE_RD     = 3'd2;
  localparam logic [2:0] MODE_RENDER = 3'd3;
  localparam logic [2:0] MODE_CLR    = 3'd4;

  // Register file map
  localparam int         NUM_REGS     = 16;
  localparam logic [3:0] REG_FINE_A   = 4'd0;
  localparam logic [3:0] REG_COARSE_A = 4'd1;
  localparam logic [3:0] REG_FINE_B   = 4'd2;
  localparam logic [3:0] REG_COARSE_B = 4'd3;
  localparam logic [3:0] REG_FINE_C   = 4'd4;
  localparam logic [3:0] REG_COARSE_C = 4'd5;
  localparam logic [3:0] REG_NOISE    = 4'd6;
  localparam logic [3:0] REG_MIXER    = 4'd7;
  localparam logic [3:0] REG_VOL_A    = 4'd8;
  localparam logic [3:0] REG_VOL_B    = 4'd9;
  localparam logic [3:0] REG_VOL_C    = 4'd10;
  localparam logic [3:0] REG_ENV_LO   = 4'd11;
  localparam logic [3:0] REG_ENV_HI   = 4'd12;
  localparam logic [3:0] REG_SHAPE    = 4'd13;

  localparam logic [7:0]  MIXER_RESET = 8'hFF;
  localparam logic [7:0]  READ_MISS   = 8'hFF;
  localparam logic [14:0] SR_DEFAULT  = 15'd15600;

  // Per-sample counter increments
  localparam logic [31:0] TONE_INCREMENT     = 32'd110837;
  localparam logic [31:0] ENVELOPE_INCREMENT = 32'd6927;

  // Output scaling: ceil(32767 * 2^29 / 19878), exact for sums up to 19878
  localparam logic [29:0] SCALE_RECIP = 30'd884980842;

  // Divider geometry: quotients never reach 2^17
  localparam int DIVD_W = 32;
  localparam int DIVS_W = 31;
  localparam int QUOT_W = 17;
  localparam int NZ_W   = 17;

  // Front queue
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] data;
  } psg_in_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [14:0] sample;
  } psg_out_t;

  typedef enum logic [2:0] {
    OP_SEL, OP_WR, OP_RD, OP_RENDER, OP_CLR, OP_NOP
  } psg_op_e;

  typedef struct packed {
    psg_op_e    op;
    logic [7:0] data;
  } psg_op_t;

  typedef struct packed {
    logic    valid;
    psg_op_t item;
  } psg_q_t;

  // Noise LFSR jump matrices: entry k advances the register by 2^k steps
  typedef logic [NZ_W-1:0][NZ_W-1:0] nz_mat_t;
  typedef nz_mat_t [QUOT_W-1:0]      nz_jumps_t;

  function automatic nz_mat_t nz_mat_mul(nz_mat_t a, nz_mat_t b);
    nz_mat_t c;
    logic    acc;
    c = '0;
    for (int i = 0; i < NZ_W; i++) begin
      for (int j = 0; j < NZ_W; j++) begin
        acc = 1'b0;
        for (int k = 0; k < NZ_W; k++) acc = acc ^ (a[i][k] & b[k][j]);
        c[i][j] = acc;
      end
    end
    return c;
  endfunction

  function automatic nz_jumps_t nz_jumps_f();
    nz_jumps_t j;
    nz_mat_t   m;
    m = '0;
    for (int i = 0; i < NZ_W - 1; i++) m[i][i+1] = 1'b1;
    m[NZ_W-1][0] = 1'b1;
    m[NZ_W-1][3] = 1'b1;
    j[0] = m;
    for (int k = 1; k < QUOT_W; k++) j[k] = nz_mat_mul(j[k-1], j[k-1]);
    return j;
  endfunction

  localparam nz_jumps_t NZ_JUMPS = nz_jumps_f();

  function automatic logic [NZ_W-1:0] nz_apply(nz_mat_t m, logic [NZ_W-1:0] s);
    logic [NZ_W-1:0] r;
    for (int i = 0; i < NZ_W; i++) r[i] = ^(m[i] & s);
    return r;
  endfunction

  // Logarithmic volume table
  function automatic logic [12:0] dac_level(logic [3:0] vol);
    logic [12:0] v;
    case (vol)
      4'd0:    v = 13'd0;
      4'd1:    v = 13'd51;
      4'd2:    v = 13'd73;
      4'd3:    v = 13'd103;
      4'd4:    v = 13'd146;
      4'd5:    v = 13'd207;
      4'd6:    v = 13'd292;
      4'd7:    v = 13'd414;
      4'd8:    v = 13'd585;
      4'd9:    v = 13'd828;
      4'd10:   v = 13'd1171;
      4'd11:   v = 13'd1656;
      4'd12:   v = 13'd2342;
      4'd13:   v = 13'd3313;
      4'd14:   v = 13'd4685;
      default: v = 13'd6626;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/psg_front.sv =====
// Front end: takes bus items, decodes the mode and holds them in a short queue.
// Depends on psg_pkg.
module psg_front import psg_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  psg_in_t in_data_i,
  input  logic    pop_i,
  output psg_q_t  head_o
);

  psg_op_t    slot_q [QUEUE_DEPTH];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  psg_op_t    dec;
  logic       push, pop;

  // Mode decode
  always_comb begin
    dec.data = in_data_i.data;
    case (in_data_i.mode)
      MODE_SEL:    dec.op = OP_SEL;
      MODE_WR:     dec.op = OP_WR;
      MODE_RD:     dec.op = OP_RD;
      MODE_RENDER: dec.op = OP_RENDER;
      MODE_CLR:    dec.op = OP_CLR;
      default:     dec.op = OP_NOP;
    endcase
  end

  assign in_stall_o = (count_q == 2'(QUEUE_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (count_q != 2'd0);

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.item  = slot_q[rd_ptr_q];

  // Queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop)      count_q <= count_q + 2'd1;
      else if (pop && !push) count_q <= count_q - 2'd1;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= dec;
  end

endmodule

// ===== hdl/psg_div.sv =====
// Shared restoring divider, one quotient bit per cycle, 17 steps.
// Depends on psg_pkg; the dividend over 2^17 must stay below the divisor.
module psg_div import psg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIVD_W-1:0] dividend_i,
  input  logic [DIVS_W-1:0] divisor_i,
  output logic              done_o,
  output logic [QUOT_W-1:0] quot_o,
  output logic [DIVS_W-1:0] rem_o
);

  logic              busy_q, done_q;
  logic [4:0]        cnt_q;
  logic [DIVS_W-1:0] rem_q, dvs_q;
  logic [QUOT_W-1:0] low_q, quot_q;
  logic [DIVS_W:0]   trial;
  logic              ge;

  // One trial subtraction per step
  assign trial = {rem_q, low_q[QUOT_W-1]};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(QUOT_W - 1);
      end else if (busy_q) begin
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 5'd1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= DIVS_W'(dividend_i[DIVD_W-1:QUOT_W]);
      low_q  <= dividend_i[QUOT_W-1:0];
      dvs_q  <= divisor_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? DIVS_W'(trial - {1'b0, dvs_q}) : trial[DIVS_W-1:0];
      low_q  <= {low_q[QUOT_W-2:0], 1'b0};
      quot_q <= {quot_q[QUOT_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ===== hdl/psg_back.sv =====
// Back end: register file, voice state, render sequencer and result register.
// Depends on psg_pkg and psg_div.
module psg_back import psg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [14:0] cfg_wdata_i,
  input  psg_q_t      head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output psg_out_t    out_data_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_GO    = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_NOISE = 3'd4;
  localparam logic [2:0] ST_MIX   = 3'd5;

  localparam logic [2:0] UNIT_TONE_A = 3'd0;
  localparam logic [2:0] UNIT_TONE_B = 3'd1;
  localparam logic [2:0] UNIT_TONE_C = 3'd2;
  localparam logic [2:0] UNIT_NOISE  = 3'd3;
  localparam logic [2:0] UNIT_ENV    = 3'd4;
  localparam logic [2:0] UNIT_SCALE  = 3'd5;

  logic [14:0]       sr_q;
  logic [3:0]        sel_q;
  logic [7:0]        reg_q [NUM_REGS];
  logic [27:0]       tacc_q [3];
  logic [2:0]        tlvl_q;
  logic [19:0]       nacc_q;
  logic [NZ_W-1:0]   nsr_q;
  logic              nlvl_q;
  logic [31:0]       eacc_q;
  logic [4:0]        epos_q;
  logic              efrz_q;
  logic [3:0]        elvl_q;
  logic [2:0]        state_q, u_q;
  logic [4:0]        k_q;
  logic [DIVD_W-1:0] acc_q;
  logic [DIVS_W-1:0] thr_q;
  logic              out_vld_q;
  psg_out_t          out_q;

  logic              div_start, div_done;
  logic [QUOT_W-1:0] quot;
  logic [DIVS_W-1:0] rem;

  logic [15:0]       per_raw, per_eff;
  logic [14:0]       sr_eff;
  logic [31:0]       acc_base, inc, acc_next;
  logic [30:0]       thr_next;
  logic [17:0]       epos_sum;
  logic [4:0]        epos_new;
  logic              efrz_new;
  logic [14:0]       total;
  logic [44:0]       scale_prod;
  logic [15:0]       scaled;
  logic [17:0]       s3;
  logic [7:0]        wdata;
  logic [7:0]        rd_word;
  logic [NZ_W-1:0]   nsr_jump;
  logic              take, out_free;

  // Envelope level for a shape and a step
  function automatic logic [3:0] shape_level(logic [3:0] shape, logic [4:0] pos);
    logic [3:0] p, up, dn, r;
    p  = pos[3:0];
    up = p;
    dn = 4'd15 - p;
    if (!pos[4])        r = shape[2] ? up : dn;
    else if (!shape[3]) r = 4'd0;
    else if (shape[0])  r = (shape[1] != shape[2]) ? 4'd15 : 4'd0;
    else if (shape[1])  r = shape[2] ? dn : up;
    else                r = shape[2] ? up : dn;
    return r;
  endfunction

  psg_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(acc_q),
    .divisor_i (thr_q),
    .done_o    (div_done),
    .quot_o    (quot),
    .rem_o     (rem)
  );

  assign div_start = (state_q == ST_GO);
  assign take      = out_vld_q && !out_stall_i;
  assign out_free  = !out_vld_q || !out_stall_i;
  assign pop_o     = (state_q == ST_IDLE) && head_i.valid && out_free;

  // Period, accumulator and increment of the counter in progress
  always_comb begin
    per_raw  = '0;
    acc_base = '0;
    inc      = TONE_INCREMENT;
    case (u_q)
      UNIT_TONE_A: begin
        per_raw  = {4'd0, reg_q[REG_COARSE_A][3:0], reg_q[REG_FINE_A]};
        acc_base = {4'd0, tacc_q[0]};
      end
      UNIT_TONE_B: begin
        per_raw  = {4'd0, reg_q[REG_COARSE_B][3:0], reg_q[REG_FINE_B]};
        acc_base = {4'd0, tacc_q[1]};
      end
      UNIT_TONE_C: begin
        per_raw  = {4'd0, reg_q[REG_COARSE_C][3:0], reg_q[REG_FINE_C]};
        acc_base = {4'd0, tacc_q[2]};
      end
      UNIT_NOISE: begin
        per_raw  = {11'd0, reg_q[REG_NOISE][4:0]};
        acc_base = {12'd0, nacc_q};
      end
      UNIT_ENV: begin
        per_raw  = {reg_q[REG_ENV_HI], reg_q[REG_ENV_LO]};
        acc_base = eacc_q;
        inc      = ENVELOPE_INCREMENT;
      end
      default: begin
        per_raw  = '0;
        acc_base = '0;
      end
    endcase
  end

  assign per_eff  = (per_raw == 16'd0) ? 16'd1 : per_raw;
  assign sr_eff   = (sr_q == 15'd0) ? SR_DEFAULT : sr_q;
  assign thr_next = per_eff * sr_eff;
  assign acc_next = acc_base + inc;

  // Envelope step advance and end handling
  always_comb begin
    epos_sum = 18'(epos_q) + 18'(quot);
    efrz_new = 1'b0;
    epos_new = epos_sum[4:0];
    if (epos_sum >= 18'd32) begin
      if (!reg_q[REG_SHAPE][3] || reg_q[REG_SHAPE][0]) begin
        efrz_new = 1'b1;
        epos_new = 5'd31;
      end
    end
  end

  // Mixer gating and volume sum
  always_comb begin
    logic t, n;
    logic [7:0] v;
    logic [3:0] vol;
    total = '0;
    for (int ch = 0; ch < 3; ch++) begin
      t   = reg_q[REG_MIXER][ch] ? 1'b1 : tlvl_q[ch];
      n   = reg_q[REG_MIXER][ch+3] ? 1'b1 : nlvl_q;
      v   = reg_q[4'(ch) + REG_VOL_A];
      vol = v[4] ? elvl_q : v[3:0];
      if (t && n) total = total + 15'(dac_level(vol));
    end
  end

  // Scale to 16 bits by reciprocal multiplication, then cut to three quarters
  assign scale_prod = total * SCALE_RECIP;
  assign scaled     = scale_prod[44:29];
  assign s3         = {2'd0, scaled} + {1'b0, scaled, 1'b0};
  assign nsr_jump   = nz_apply(NZ_JUMPS[k_q], nsr_q);

  // Read answer for the selected register
  assign rd_word = (32'(sel_q) < NUM_REGS) ? reg_q[sel_q] : READ_MISS;

  // Write masks per register
  always_comb begin
    wdata = head_i.item.data;
    if (sel_q inside {REG_COARSE_A, REG_COARSE_B, REG_COARSE_C, REG_SHAPE})
      wdata = head_i.item.data & 8'h0F;
    else if (sel_q inside {REG_NOISE, REG_VOL_A, REG_VOL_B, REG_VOL_C})
      wdata = head_i.item.data & 8'h1F;
  end

  // Sequencer and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_q      <= SR_DEFAULT;
      sel_q     <= '0;
      for (int i = 0; i < NUM_REGS; i++) reg_q[i] <= '0;
      reg_q[REG_MIXER] <= MIXER_RESET;
      for (int i = 0; i < 3; i++) tacc_q[i] <= '0;
      tlvl_q    <= '0;
      nacc_q    <= '0;
      nsr_q     <= NZ_W'(1);
      nlvl_q    <= 1'b0;
      eacc_q    <= '0;
      epos_q    <= '0;
      efrz_q    <= 1'b0;
      elvl_q    <= '0;
      state_q   <= ST_IDLE;
      u_q       <= UNIT_TONE_A;
      k_q       <= '0;
      acc_q     <= '0;
      thr_q     <= '0;
      out_vld_q <= 1'b0;
      out_q     <= '0;
    end else begin
      if (cfg_we_i) sr_q <= cfg_wdata_i;
      if (take) out_vld_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            out_vld_q <= 1'b1;
            out_q     <= '{read_data: (head_i.item.op == OP_RD) ? rd_word : 8'd0,
                           sample: 15'd0};
            case (head_i.item.op)
              OP_SEL: sel_q <= head_i.item.data[3:0];
              OP_WR: begin
                if (32'(sel_q) < NUM_REGS) begin
                  reg_q[sel_q] <= wdata;
                  if (sel_q == REG_SHAPE) begin
                    epos_q <= '0;
                    eacc_q <= '0;
                    efrz_q <= 1'b0;
                  end
                end
              end
              OP_RENDER: begin
                out_vld_q <= 1'b0;
                u_q       <= UNIT_TONE_A;
                state_q   <= ST_MUL;
              end
              OP_CLR: begin
                sel_q <= '0;
                for (int i = 0; i < NUM_REGS; i++) reg_q[i] <= '0;
                reg_q[REG_MIXER] <= MIXER_RESET;
                for (int i = 0; i < 3; i++) tacc_q[i] <= '0;
                tlvl_q <= '0;
                nacc_q <= '0;
                nsr_q  <= NZ_W'(1);
                nlvl_q <= 1'b0;
                eacc_q <= '0;
                epos_q <= '0;
                efrz_q <= 1'b0;
                elvl_q <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_MUL: begin
          if (u_q == UNIT_ENV && efrz_q) begin
            u_q     <= UNIT_SCALE;
            state_q <= ST_MIX;
          end else begin
            acc_q   <= acc_next;
            thr_q   <= thr_next;
            state_q <= ST_GO;
          end
        end
        ST_GO: state_q <= ST_WAIT;
        ST_WAIT: begin
          if (div_done) begin
            case (u_q)
              UNIT_TONE_A, UNIT_TONE_B, UNIT_TONE_C: begin
                tacc_q[u_q[1:0]] <= rem[27:0];
                tlvl_q[u_q[1:0]] <= tlvl_q[u_q[1:0]] ^ quot[0];
                u_q     <= u_q + 3'd1;
                state_q <= ST_MUL;
              end
              UNIT_NOISE: begin
                nacc_q <= rem[19:0];
                k_q    <= '0;
                if (quot != '0) begin
                  state_q <= ST_NOISE;
                end else begin
                  u_q     <= UNIT_ENV;
                  state_q <= ST_MUL;
                end
              end
              UNIT_ENV: begin
                eacc_q  <= {1'b0, rem};
                epos_q  <= epos_new;
                efrz_q  <= efrz_new;
                elvl_q  <= shape_level(reg_q[REG_SHAPE][3:0], epos_new);
                u_q     <= UNIT_SCALE;
                state_q <= ST_MIX;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_NOISE: begin
          if (quot[k_q]) nsr_q <= nsr_jump;
          if (k_q == 5'(QUOT_W - 1)) begin
            nlvl_q  <= quot[k_q] ? nsr_jump[0] : nsr_q[0];
            u_q     <= UNIT_ENV;
            state_q <= ST_MUL;
          end else begin
            k_q <= k_q + 5'd1;
          end
        end
        ST_MIX: begin
          out_vld_q <= 1'b1;
          out_q     <= '{read_data: 8'd0, sample: s3[16:2]};
          state_q   <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/psg_three_voice_sound_generator.sv =====
// Top level of the three-voice sound generator.
// Depends on psg_pkg, psg_front and psg_back (which holds psg_div).
//
// Each input item is one bus operation (select, write, read, soft reset) or a
// render request, and gives exactly one result. Bus operations give their
// result in the cycle after they leave the two-entry input queue. A render
// runs the counter divisions for the three tones, the noise and the envelope
// on the single shared divider, each with setup, start, 17 quotient steps and
// the done cycle; a noise register jump follows the noise division when the
// noise counter steps, and mixing and scaling come last. While the envelope
// holds its division is skipped. Write the sample rate only while the block
// is idle.
module psg_three_voice_sound_generator import psg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [14:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  psg_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output psg_out_t    out_data_o
);

  psg_q_t head;
  logic   pop;

  // Intake and queue
  psg_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .pop_i     (pop),
    .head_o    (head)
  );

  // Execution and result register
  psg_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .head_i     (head),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
